// File: rtl/core/extendible_hash_directory_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extendible hash directory
// Short forms for the concurrent checks used in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef EXTENDIBLE_HASH_DIRECTORY_MACROS_SVH
`define EXTENDIBLE_HASH_DIRECTORY_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define EHD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Same-cycle implication
`define EHD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ehd_pkg.sv
// ----------------------------------------------------------------------------
// Extendible hash directory package
// Field widths, operation and status codes, sequencer steps and the
// microprogram that drives the directory datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ehd_pkg;

   // Default sizing
   localparam int EHD_MAX_DEPTH = 9;
   localparam int EHD_DIR_SLOTS = 512;

   // Fixed field widths of the request and response words
   localparam int OP_W   = 3;
   localparam int IDX_W  = 9;
   localparam int PAGE_W = 32;
   localparam int LD_W   = 4;
   localparam int ST_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 3'd0,
      OP_SET    = 3'd1,
      OP_INCR   = 3'd2,
      OP_DECR   = 3'd3,
      OP_EXPAND = 3'd4,
      OP_SHRINK = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOSHRINK = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   // Sequencer steps (microprogram addresses)
   typedef enum logic [3:0] {
      S_IDLE = 4'd0,
      S_MOD  = 4'd1,
      S_EXP  = 4'd2,
      S_CPR  = 4'd3,
      S_CPW  = 4'd4,
      S_EXE  = 4'd5,
      S_OUT  = 4'd6,
      S_FULL = 4'd7,
      S_SHK  = 4'd8,
      S_SWR  = 4'd9,
      S_SWC  = 4'd10,
      S_SHE  = 4'd11,
      S_NOSH = 4'd12
   } step_type;

   typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_WALK} rd_type;
   typedef enum logic [1:0] {WR_NONE, WR_ENTRY, WR_COPY} wr_type;
   typedef enum logic [1:0] {WK_HOLD, WK_CLEAR, WK_EXP, WK_SHK} walk_type;
   typedef enum logic [1:0] {GD_HOLD, GD_INC, GD_DEC} gd_type;
   typedef enum logic [1:0] {RES_NONE, RES_ENTRY, RES_READ} res_type;
   typedef enum logic [1:0] {C_NEVER, C_FULL, C_NO_SHRINK, C_WALK_LAST} cond_type;

   // One control word of the microprogram
   typedef struct packed {
      rd_type     rd;
      wr_type     wr;
      walk_type   walk;
      gd_type     gd;
      logic       split;
      res_type    res;
      status_type res_status;
      cond_type   cond;
      step_type   jump;
      step_type   next;
      logic       dispatch;
   } ctrl_type;

   // Status flags from the datapath back to the sequencer
   typedef struct packed {
      logic full;
      logic no_shrink;
      logic walk_last;
      logic res_hold;
   } flags_type;

   localparam ctrl_type CTRL_NOP = '{
      rd: RD_NONE, wr: WR_NONE, walk: WK_HOLD, gd: GD_HOLD, split: 1'b0,
      res: RES_NONE, res_status: ST_OK, cond: C_NEVER, jump: S_IDLE,
      next: S_IDLE, dispatch: 1'b0
   };

   // Microprogram ROM
   function automatic ctrl_type control_word(input step_type step);
      ctrl_type w;
      w = CTRL_NOP;
      case (step)
         S_IDLE: begin
            w.rd       = RD_IDX;
            w.dispatch = 1'b1;
         end
         S_MOD: begin
            w.wr  = WR_ENTRY;
            w.res = RES_ENTRY;
         end
         S_EXP: begin
            w.walk = WK_CLEAR;
            w.cond = C_FULL;
            w.jump = S_FULL;
            w.next = S_CPR;
         end
         S_CPR: begin
            w.rd   = RD_WALK;
            w.next = S_CPW;
         end
         S_CPW: begin
            w.wr   = WR_COPY;
            w.walk = WK_EXP;
            w.cond = C_WALK_LAST;
            w.jump = S_EXE;
            w.next = S_CPR;
         end
         S_EXE: begin
            w.gd    = GD_INC;
            w.split = 1'b1;
            w.rd    = RD_IDX;
            w.next  = S_OUT;
         end
         S_OUT: begin
            w.res        = RES_READ;
            w.res_status = ST_OK;
         end
         S_FULL: begin
            w.res        = RES_READ;
            w.res_status = ST_FULL;
         end
         S_SHK: begin
            w.walk = WK_CLEAR;
            w.cond = C_NO_SHRINK;
            w.jump = S_NOSH;
            w.next = S_SWR;
         end
         S_SWR: begin
            w.rd   = RD_WALK;
            w.next = S_SWC;
         end
         S_SWC: begin
            w.walk = WK_SHK;
            w.cond = C_WALK_LAST;
            w.jump = S_SHE;
            w.next = S_SWR;
         end
         S_SHE: begin
            w.gd   = GD_DEC;
            w.rd   = RD_IDX;
            w.next = S_OUT;
         end
         S_NOSH: begin
            w.res        = RES_READ;
            w.res_status = ST_NOSHRINK;
         end
         default: w = CTRL_NOP;
      endcase
      return w;
   endfunction

   // First step of each operation; unused selector codes act as lookup
   function automatic step_type dispatch_step(input logic [OP_W-1:0] op);
      step_type s;
      case (op_type'(op))
         OP_EXPAND: s = S_EXP;
         OP_SHRINK: s = S_SHK;
         default:   s = S_MOD;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ehd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data that holds while
// no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ehd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/ehd_sequencer.sv
// ----------------------------------------------------------------------------
// Directory sequencer
// Step counter over the microprogram ROM: dispatch on the operation,
// conditional jumps on datapath flags, hold while the response is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ehd_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [ehd_pkg::OP_W-1:0]    req_operation,
   input  wire ehd_pkg::flags_type          flags,
   output logic                             req_stall,
   output logic                             accept,
   output ehd_pkg::ctrl_type                ctrl
);

   import ehd_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     take_jump;

   // control word for the current step
   always_comb begin
      ctrl      = control_word(step_ff);
      req_stall = !ctrl.dispatch;
      accept    = req_valid && ctrl.dispatch;
   end

   // jump condition
   always_comb begin
      case (ctrl.cond)
         C_FULL:      take_jump = flags.full;
         C_NO_SHRINK: take_jump = flags.no_shrink;
         C_WALK_LAST: take_jump = flags.walk_last;
         default:     take_jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (ctrl.dispatch) begin
         step_in = accept ? dispatch_step(req_operation) : S_IDLE;
      end else if (flags.res_hold) begin
         step_in = step_ff;
      end else if (take_jump) begin
         step_in = ctrl.jump;
      end else begin
         step_in = ctrl.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ehd_datapath.sv
// ----------------------------------------------------------------------------
// Directory datapath
// Slot RAM (page id and local depth), global depth, count of live slots at
// the global depth, walk counter, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "extendible_hash_directory_macros.svh"

module ehd_datapath #(
   parameter int MAX_DEPTH = ehd_pkg::EHD_MAX_DEPTH,
   parameter int DIR_SLOTS = ehd_pkg::EHD_DIR_SLOTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ehd_pkg::ctrl_type                 ctrl,
   input  wire logic                              accept,
   output ehd_pkg::flags_type                     flags,
   input  wire logic        [ehd_pkg::OP_W-1:0]   req_operation,
   input  wire logic        [ehd_pkg::IDX_W-1:0]  req_bucket_index,
   input  wire logic signed [ehd_pkg::PAGE_W-1:0] req_page_id_value,
   input  wire logic        [ehd_pkg::LD_W-1:0]   req_new_local_depth,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [ehd_pkg::PAGE_W-1:0] rsp_page_id_out,
   output logic             [ehd_pkg::LD_W-1:0]   rsp_local_depth_out,
   output logic             [ehd_pkg::IDX_W-1:0]  rsp_brother_index,
   output logic             [ehd_pkg::LD_W-1:0]   rsp_global_depth_out,
   output logic                                   rsp_shrink_allowed,
   output logic                                   rsp_split_valid,
   output logic             [ehd_pkg::IDX_W-1:0]  rsp_split_index,
   output logic             [ehd_pkg::ST_W-1:0]   rsp_status
);

   import ehd_pkg::*;

   localparam int AW        = $clog2(DIR_SLOTS);
   localparam int CW        = AW + 1;
   localparam int DW        = $clog2(MAX_DEPTH + 1);
   localparam int FLOOR_LOG = $clog2(DIR_SLOTS + 1) - 1;
   localparam int GD_LIMIT  = (MAX_DEPTH < FLOOR_LOG) ? MAX_DEPTH : FLOOR_LOG;
   localparam int MW        = PAGE_W + DW;
   localparam int LW        = (CW > IDX_W) ? CW : IDX_W;

   // captured request
   logic [OP_W-1:0]   op_ff, op_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PAGE_W-1:0] pid_ff, pid_in;
   logic [LD_W-1:0]   nld_ff, nld_in;

   // directory state
   logic [DW-1:0] gd_ff, gd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic          slot0_ok_ff, slot0_ok_in;
   logic          rd_zero_ff, rd_zero_in;
   logic          split_valid_ff, split_valid_in;
   logic [IDX_W-1:0] split_index_ff, split_index_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0] res_page_ff, res_page_in;
   logic [DW-1:0]     res_ld_ff, res_ld_in;
   logic [IDX_W-1:0]  res_bro_ff, res_bro_in;
   logic [DW-1:0]     res_gd_ff, res_gd_in;
   logic              res_shrink_ff, res_shrink_in;
   logic              res_split_valid_ff, res_split_valid_in;
   logic [IDX_W-1:0]  res_split_index_ff, res_split_index_in;
   status_type        res_status_ff, res_status_in;

   // RAM port signals
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [MW-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0]     size;
   logic [CW-1:0]     walk_limit;
   logic              idx_live;
   logic [PAGE_W-1:0] rd_page;
   logic [DW-1:0]     rd_ld;
   logic [DW-1:0]     set_ld;
   logic [PAGE_W-1:0] new_pg;
   logic [DW-1:0]     new_ld;
   logic              modify;
   logic              entry_go;
   logic              res_hold;
   logic              res_load;
   logic [PAGE_W-1:0] sel_pg;
   logic [DW-1:0]     sel_ld;
   logic [CW-1:0]     sel_cnt;
   logic [AW-1:0]     idx_addr;

   function automatic logic [IDX_W-1:0] brother_of(input logic [IDX_W-1:0] idx,
                                                   input logic [DW-1:0]    ld);
      return (ld == '0) ? '0 : (idx ^ (IDX_W'(1) << (ld - 1'b1)));
   endfunction

   ehd_ram #(
      .WIDTH (MW),
      .DEPTH (DIR_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // live size and slot decode
   always_comb begin
      size       = CW'(1) << gd_ff;
      walk_limit = (ctrl.walk == WK_SHK) ? (size >> 1) : size;
      idx_live   = LW'(idx_ff) < LW'(size);
      rd_page    = ram_rdata[MW-1 -: PAGE_W];
      rd_ld      = rd_zero_ff ? '0 : ram_rdata[DW-1:0];
      set_ld     = (int'(nld_ff) > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(nld_ff);
   end

   // flags to the sequencer
   always_comb begin
      res_hold        = (ctrl.res != RES_NONE) && rsp_valid_ff && rsp_stall;
      res_load        = (ctrl.res != RES_NONE) && !res_hold;
      flags.res_hold  = res_hold;
      flags.full      = int'(gd_ff) >= GD_LIMIT;
      flags.no_shrink = (gd_ff == '0) || (cnt_ff != '0);
      flags.walk_last = CW'(walk_ff + 1'b1) == walk_limit;
   end

   // entry read-modify-write
   always_comb begin
      new_pg = rd_page;
      new_ld = rd_ld;
      modify = 1'b0;
      case (op_type'(op_ff))
         OP_SET: begin
            new_pg = pid_ff;
            new_ld = set_ld;
            modify = 1'b1;
         end
         OP_INCR: begin
            if (int'(rd_ld) < MAX_DEPTH) begin
               new_ld = rd_ld + 1'b1;
            end
            modify = 1'b1;
         end
         OP_DECR: begin
            if (rd_ld != '0) begin
               new_ld = rd_ld - 1'b1;
            end
            modify = 1'b1;
         end
         default: modify = 1'b0;
      endcase
      entry_go = (ctrl.wr == WR_ENTRY) && !res_hold && modify && idx_live;
   end

   // RAM port control
   always_comb begin
      idx_addr  = ctrl.dispatch ? AW'(req_bucket_index) : AW'(idx_ff);
      ram_re    = (ctrl.rd != RD_NONE) && (!ctrl.dispatch || accept);
      ram_raddr = (ctrl.rd == RD_WALK) ? AW'(walk_ff) : idx_addr;
      ram_we    = entry_go || (ctrl.wr == WR_COPY);
      if (ctrl.wr == WR_COPY) begin
         ram_waddr = AW'(walk_ff + size);
         ram_wdata = {rd_page, rd_ld};
      end else begin
         ram_waddr = AW'(idx_ff);
         ram_wdata = {new_pg, new_ld};
      end
   end

   // request capture
   always_comb begin
      op_in  = op_ff;
      idx_in = idx_ff;
      pid_in = pid_ff;
      nld_in = nld_ff;
      if (accept) begin
         op_in  = req_operation;
         idx_in = req_bucket_index;
         pid_in = $unsigned(req_page_id_value);
         nld_in = req_new_local_depth;
      end
   end

   // directory state update
   always_comb begin
      gd_in          = gd_ff;
      cnt_in         = cnt_ff;
      walk_in        = walk_ff;
      acc_in         = acc_ff;
      split_valid_in = split_valid_ff;
      split_index_in = split_index_ff;
      slot0_ok_in    = slot0_ok_ff || (ram_we && (ram_waddr == '0));
      rd_zero_in     = ram_re ? ((ram_raddr == '0) && !slot0_ok_ff) : rd_zero_ff;

      // keep the live count at the global depth in step with entry writes
      if (entry_go) begin
         cnt_in = cnt_ff - CW'(rd_ld == gd_ff) + CW'(new_ld == gd_ff);
      end

      case (ctrl.walk)
         WK_CLEAR: begin
            walk_in = '0;
            acc_in  = '0;
         end
         WK_EXP: begin
            walk_in = walk_ff + 1'b1;
            acc_in  = acc_ff + CW'(rd_ld == DW'(gd_ff + 1'b1));
         end
         WK_SHK: begin
            walk_in = walk_ff + 1'b1;
            acc_in  = acc_ff + CW'(rd_ld == DW'(gd_ff - 1'b1));
         end
         default: walk_in = walk_ff;
      endcase

      case (ctrl.gd)
         GD_INC: begin
            gd_in  = gd_ff + 1'b1;
            cnt_in = {acc_ff[CW-2:0], 1'b0};
         end
         GD_DEC: begin
            gd_in  = gd_ff - 1'b1;
            cnt_in = acc_ff;
         end
         default: gd_in = gd_ff;
      endcase

      // split slot of an expand, cleared for every new word
      if (accept) begin
         split_valid_in = 1'b0;
         split_index_in = '0;
      end else if (ctrl.split) begin
         split_valid_in = idx_live;
         split_index_in = idx_live ? IDX_W'(LW'(size) + LW'(idx_ff)) : '0;
      end
   end

   // response assembly
   always_comb begin
      if (ctrl.res == RES_ENTRY) begin
         sel_pg  = new_pg;
         sel_ld  = new_ld;
         sel_cnt = cnt_in;
      end else begin
         sel_pg  = rd_page;
         sel_ld  = rd_ld;
         sel_cnt = cnt_ff;
      end

      res_page_in        = res_page_ff;
      res_ld_in          = res_ld_ff;
      res_bro_in         = res_bro_ff;
      res_gd_in          = res_gd_ff;
      res_shrink_in      = res_shrink_ff;
      res_split_valid_in = res_split_valid_ff;
      res_split_index_in = res_split_index_ff;
      res_status_in      = res_status_ff;
      if (res_load) begin
         res_page_in        = idx_live ? sel_pg : '0;
         res_ld_in          = idx_live ? sel_ld : '0;
         res_bro_in         = idx_live ? brother_of(idx_ff, sel_ld) : '0;
         res_gd_in          = gd_ff;
         res_shrink_in      = (gd_ff != '0) && (sel_cnt == '0);
         res_split_valid_in = split_valid_ff;
         res_split_index_in = split_index_ff;
         res_status_in      = (!idx_live && (ctrl.res_status == ST_OK)) ? ST_RANGE
                                                                        : ctrl.res_status;
      end

      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gd_ff        <= '0;
         cnt_ff       <= CW'(1);
         slot0_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gd_ff        <= gd_in;
         cnt_ff       <= cnt_in;
         slot0_ok_ff  <= slot0_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      idx_ff             <= idx_in;
      pid_ff             <= pid_in;
      nld_ff             <= nld_in;
      walk_ff            <= walk_in;
      acc_ff             <= acc_in;
      rd_zero_ff         <= rd_zero_in;
      split_valid_ff     <= split_valid_in;
      split_index_ff     <= split_index_in;
      res_page_ff        <= res_page_in;
      res_ld_ff          <= res_ld_in;
      res_bro_ff         <= res_bro_in;
      res_gd_ff          <= res_gd_in;
      res_shrink_ff      <= res_shrink_in;
      res_split_valid_ff <= res_split_valid_in;
      res_split_index_ff <= res_split_index_in;
      res_status_ff      <= res_status_in;
   end

   // response ports
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_page_id_out      = $signed(res_page_ff);
   assign rsp_local_depth_out  = LD_W'(res_ld_ff);
   assign rsp_brother_index    = res_bro_ff;
   assign rsp_global_depth_out = LD_W'(res_gd_ff);
   assign rsp_shrink_allowed   = res_shrink_ff;
   assign rsp_split_valid      = res_split_valid_ff;
   assign rsp_split_index      = res_split_index_ff;
   assign rsp_status           = res_status_ff;

   // checks
   `EHD_ASSERT_ALWAYS(a_cnt_in_range, clock, reset, cnt_ff <= size,
      "count of slots at global depth exceeds live size")
   `EHD_ASSERT_ALWAYS(a_no_rw_clash, clock, reset, !(ram_we && ram_re),
      "slot RAM read and written in the same cycle")
   `EHD_ASSERT_IMPL(a_copy_above_live, clock, reset, ram_we && (ctrl.wr == WR_COPY),
      CW'(ram_waddr) >= size, "expand copy writes into the live half")
   `EHD_ASSERT_IMPL(a_walk_in_range, clock, reset,
      (ctrl.walk == WK_EXP) || (ctrl.walk == WK_SHK), walk_ff < size,
      "directory walk ran past the live size")
   `EHD_ASSERT_IMPL(a_shrink_needs_depth, clock, reset, rsp_valid_ff && res_shrink_ff,
      res_gd_ff != '0, "shrink reported possible at global depth zero")

endmodule

`default_nettype wire

// File: rtl/core/extendible_hash_directory.sv
// ----------------------------------------------------------------------------
// Extendible hash directory
// Global depth plus a slot table of bucket page id and local depth, driven
// by a microcoded sequencer over a single slot RAM.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  operation, index, page id, depth
//   rsp_     out        rsp_valid/rsp_stall  slot, brother, depth, split, status
//
// Lookup, set entry, increment and decrement: RAM read on accept, then a
// read-modify-write step over the one read and one write port. Expand reads
// each live slot and copies it into the upper half, then raises the global
// depth; shrink walks over the lower half, then lowers the depth; a refused
// expand or shrink goes straight to its status step.
// Reset clears the control state; no clearing pass is run.
// A finished word waits in the response register under rsp_stall while the
// next request is accepted; the following result holds its step until free.
// ----------------------------------------------------------------------------
`default_nettype none

module extendible_hash_directory #(
   parameter int MAX_DEPTH = ehd_pkg::EHD_MAX_DEPTH,
   parameter int DIR_SLOTS = ehd_pkg::EHD_DIR_SLOTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic        [ehd_pkg::OP_W-1:0]   req_operation,
   input  wire logic        [ehd_pkg::IDX_W-1:0]  req_bucket_index,
   input  wire logic signed [ehd_pkg::PAGE_W-1:0] req_page_id_value,
   input  wire logic        [ehd_pkg::LD_W-1:0]   req_new_local_depth,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [ehd_pkg::PAGE_W-1:0] rsp_page_id_out,
   output logic             [ehd_pkg::LD_W-1:0]   rsp_local_depth_out,
   output logic             [ehd_pkg::IDX_W-1:0]  rsp_brother_index,
   output logic             [ehd_pkg::LD_W-1:0]   rsp_global_depth_out,
   output logic                                   rsp_shrink_allowed,
   output logic                                   rsp_split_valid,
   output logic             [ehd_pkg::IDX_W-1:0]  rsp_split_index,
   output logic             [ehd_pkg::ST_W-1:0]   rsp_status
);

   import ehd_pkg::*;

   ctrl_type  ctrl;
   flags_type flags;
   logic      accept;

   // step counter and microprogram
   ehd_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .flags         (flags),
      .req_stall     (req_stall),
      .accept        (accept),
      .ctrl          (ctrl)
   );

   // slot RAM, depth state and response register
   ehd_datapath #(
      .MAX_DEPTH (MAX_DEPTH),
      .DIR_SLOTS (DIR_SLOTS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .accept               (accept),
      .flags                (flags),
      .req_operation        (req_operation),
      .req_bucket_index     (req_bucket_index),
      .req_page_id_value    (req_page_id_value),
      .req_new_local_depth  (req_new_local_depth),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_page_id_out      (rsp_page_id_out),
      .rsp_local_depth_out  (rsp_local_depth_out),
      .rsp_brother_index    (rsp_brother_index),
      .rsp_global_depth_out (rsp_global_depth_out),
      .rsp_shrink_allowed   (rsp_shrink_allowed),
      .rsp_split_valid      (rsp_split_valid),
      .rsp_split_index      (rsp_split_index),
      .rsp_status           (rsp_status)
   );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Extendible hash directory testbench
// Drives lookup, set entry, depth increment/decrement, expand and shrink
// words into the directory and checks each result word against a shadow
// copy of the slot table and global depth kept in a small scoreboard class.
// A directed opening covers depth limits, range errors, a full directory and
// refused shrinks; random traffic then follows, with bursty requests and a
// response side that stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
   import ehd_pkg::*;

   localparam int unsigned WORDS_TOTAL   = 1250;
   localparam int unsigned DRAIN_AT      = 640;
   localparam int unsigned IDLE_LIMIT    = 5000;
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned PREP_MAX      = 24;

   // One result word as seen on the response channel
   typedef struct packed {
      logic signed [PAGE_W-1:0] page_id;
      logic [LD_W-1:0]          slot_depth;
      logic [IDX_W-1:0]         brother;
      logic [LD_W-1:0]          global_depth;
      logic                     shrink_ok;
      logic                     split_valid;
      logic [IDX_W-1:0]         split_index;
      logic [ST_W-1:0]          status;
   } dir_result_type;

   // Shadow directory and queue of expected result words
   class dir_scoreboard;
      logic signed [PAGE_W-1:0] page_tab [EHD_DIR_SLOTS];
      logic [LD_W-1:0]          depth_tab [EHD_DIR_SLOTS];
      int unsigned              gdepth;
      dir_result_type           expected_q [$];
      int unsigned              mismatches;
      int unsigned              checked;
      int unsigned              op_seen [8];
      int unsigned              max_gdepth;
      int unsigned              full_seen;
      int unsigned              refused_seen;

      function new();
         foreach (depth_tab[i]) begin
            depth_tab[i] = '0;
            page_tab[i]  = '0;
         end
         foreach (op_seen[i]) op_seen[i] = 0;
         gdepth       = 0;
         mismatches   = 0;
         checked      = 0;
         max_gdepth   = 0;
         full_seen    = 0;
         refused_seen = 0;
      endfunction

      function int unsigned slots();
         return 1 << gdepth;
      endfunction

      // Shrink only when no live slot sits at the global depth
      function bit shrink_ok();
         int unsigned n;
         if (gdepth == 0) return 1'b0;
         n = slots();
         for (int unsigned i = 0; i < n; i++)
            if (depth_tab[i] == gdepth) return 1'b0;
         return 1'b1;
      endfunction

      // Apply one accepted request word and queue its result
      function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic signed [PAGE_W-1:0] pid, logic [LD_W-1:0] nld);
         dir_result_type r;
         int unsigned size;
         bit          live;
         logic [LD_W-1:0] ld;
         r    = '0;
         size = slots();
         live = idx < size;
         op_seen[op]++;
         case (op)
            OP_SET: begin
               if (live) begin
                  page_tab[idx]  = pid;
                  depth_tab[idx] = (nld > EHD_MAX_DEPTH) ? LD_W'(EHD_MAX_DEPTH) : nld;
               end
            end
            OP_INCR: begin
               if (live && depth_tab[idx] < EHD_MAX_DEPTH) depth_tab[idx]++;
            end
            OP_DECR: begin
               if (live && depth_tab[idx] > 0) depth_tab[idx]--;
            end
            OP_EXPAND: begin
               if (gdepth >= EHD_MAX_DEPTH || 2 * size > EHD_DIR_SLOTS) begin
                  r.status = ST_FULL;
                  full_seen++;
               end else begin
                  // upper half mirrors the lower half
                  for (int unsigned i = size; i < 2 * size; i++) begin
                     depth_tab[i] = depth_tab[i & (size - 1)];
                     page_tab[i]  = page_tab[i & (size - 1)];
                  end
                  if (idx < size) begin
                     r.split_valid = 1'b1;
                     r.split_index = IDX_W'(size + idx);
                  end
                  gdepth++;
               end
            end
            OP_SHRINK: begin
               if (shrink_ok()) begin
                  gdepth--;
               end else begin
                  r.status = ST_NOSHRINK;
                  refused_seen++;
               end
            end
            default: ;
         endcase
         if (gdepth > max_gdepth) max_gdepth = gdepth;
         // report the addressed slot against the size after the operation
         size = slots();
         if (idx < size) begin
            ld           = depth_tab[idx];
            r.page_id    = page_tab[idx];
            r.slot_depth = ld;
            if (ld != 0) r.brother = idx ^ (IDX_W'(1) << (ld - 1));
         end else if (r.status == ST_OK) begin
            r.status = ST_RANGE;
         end
         r.global_depth = LD_W'(gdepth);
         r.shrink_ok    = shrink_ok();
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [PAGE_W-1:0] exp_v,
                                  logic [PAGE_W-1:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
            mismatches++;
         end
      endfunction

      // Compare a result word with the oldest expectation
      function void check_response(dir_result_type got);
         dir_result_type e;
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected: page 0x%0h status %0d",
                   got.page_id, got.status);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare_field("page_id_out", e.page_id, got.page_id);
         compare_field("local_depth_out", e.slot_depth, got.slot_depth);
         compare_field("brother_index", e.brother, got.brother);
         compare_field("global_depth_out", e.global_depth, got.global_depth);
         compare_field("shrink_allowed", e.shrink_ok, got.shrink_ok);
         compare_field("split_valid", e.split_valid, got.split_valid);
         compare_field("split_index", e.split_index, got.split_index);
         compare_field("status", e.status, got.status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0] req_operation = '0;
   logic [IDX_W-1:0] req_bucket_index = '0;
   logic signed [PAGE_W-1:0] req_page_id_value = '0;
   logic [LD_W-1:0] req_new_local_depth = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [PAGE_W-1:0] rsp_page_id_out;
   logic [LD_W-1:0] rsp_local_depth_out;
   logic [IDX_W-1:0] rsp_brother_index;
   logic [LD_W-1:0] rsp_global_depth_out;
   logic rsp_shrink_allowed;
   logic rsp_split_valid;
   logic [IDX_W-1:0] rsp_split_index;
   logic [ST_W-1:0] rsp_status;

   dir_scoreboard ehd_sb = new();
   int unsigned words_sent = 0;
   int unsigned burst_left = 1;
   bit drain_req = 1'b0;
   int unsigned idle_cycles = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;

   extendible_hash_directory i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_bucket_index     (req_bucket_index),
      .req_page_id_value    (req_page_id_value),
      .req_new_local_depth  (req_new_local_depth),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_page_id_out      (rsp_page_id_out),
      .rsp_local_depth_out  (rsp_local_depth_out),
      .rsp_brother_index    (rsp_brother_index),
      .rsp_global_depth_out (rsp_global_depth_out),
      .rsp_shrink_allowed   (rsp_shrink_allowed),
      .rsp_split_valid      (rsp_split_valid),
      .rsp_split_index      (rsp_split_index),
      .rsp_status           (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response side: stretches of free flow, light, heavy and periodic stall
   always @(posedge clock) begin
      logic nxt;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 60);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            0:       nxt = 1'b0;
            1:       nxt = ($urandom_range(0, 3) == 0);
            2:       nxt = ($urandom_range(0, 3) != 0);
            default: nxt = (stall_phase % 3 == 0);
         endcase
         rsp_stall <= nxt;
      end
   end

   // Result checking and the idle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            ehd_sb.check_response('{rsp_page_id_out, rsp_local_depth_out,
                                    rsp_brother_index, rsp_global_depth_out,
                                    rsp_shrink_allowed, rsp_split_valid,
                                    rsp_split_index, rsp_status});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Present one request word, hold it until taken, then maybe idle
   task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [PAGE_W-1:0] pid,
                            input logic [LD_W-1:0] nld);
      int unsigned gap;
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_bucket_index    <= idx;
      req_page_id_value   <= pid;
      req_new_local_depth <= nld;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ehd_sb.note_request(op, idx, pid, nld);
      words_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 || drain_req) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (drain_req) begin
            // hold off until every outstanding result has come back
            req_valid <= 1'b0;
            while (ehd_sb.expected_q.size() != 0) @(posedge clock);
            drain_req = 1'b0;
         end else if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Mostly live slots, now and then anywhere in the index range
   function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
      if (n == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 511));
      return IDX_W'($urandom_range(0, n - 1));
   endfunction

   function automatic logic signed [PAGE_W-1:0] pick_page();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int unsigned size;
      int unsigned gd;
      int unsigned w_exp;
      int unsigned w_shk;
      int unsigned r;
      bit drained_once;
      logic [OP_W-1:0] op;
      logic [LD_W-1:0] nld;
      int unsigned prep_q [$];

      drained_once = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: slot 0 is written first so no unwritten page is read
      send_word(OP_SET, 9'd0, 32'h7FFF_FFFF, 4'd15);
      send_word(OP_LOOKUP, 9'd0, 32'd0, 4'd0);
      send_word(OP_INCR, 9'd0, 32'd0, 4'd0);
      send_word(OP_DECR, 9'd0, 32'd0, 4'd0);
      send_word(OP_SET, 9'd0, 32'h8000_0000, 4'd0);
      send_word(OP_DECR, 9'd0, 32'd0, 4'd0);
      send_word(OP_LOOKUP, 9'd511, 32'd0, 4'd0);
      send_word(OP_INCR, 9'd1, 32'd0, 4'd0);
      send_word(OP_SHRINK, 9'd0, 32'd0, 4'd0);
      send_word(OP_EXPAND, 9'd511, 32'd0, 4'd0);
      send_word(OP_SET, 9'd1, 32'hFFFF_FFFF, 4'd1);
      send_word(OP_LOOKUP, 9'd1, 32'd0, 4'd0);
      // grow to the maximum depth, splitting the top live slot each time
      for (int k = 1; k < EHD_MAX_DEPTH; k++)
         send_word(OP_EXPAND, IDX_W'((1 << k) - 1), 32'd0, 4'd0);
      send_word(OP_EXPAND, 9'd0, 32'd0, 4'd0);
      send_word(OP_SET, 9'd511, 32'd0, 4'd15);
      send_word(OP_SHRINK, 9'd511, 32'd0, 4'd0);
      send_word(OP_DECR, 9'd511, 32'd0, 4'd0);
      send_word(OP_SHRINK, 9'd3, 32'd0, 4'd0);
      send_word(OP_W'(6), 9'd3, 32'h5A5A_A5A5, 4'd9);
      send_word(OP_W'(7), 9'd300, 32'hA5A5_5A5A, 4'd6);

      // Random traffic, biased so the directory keeps growing and shrinking
      while (words_sent < WORDS_TOTAL) begin
         if (!drained_once && words_sent >= DRAIN_AT) begin
            drain_req    = 1'b1;
            drained_once = 1'b1;
         end
         size  = ehd_sb.slots();
         gd    = ehd_sb.gdepth;
         w_exp = (gd < 3) ? 20 : (gd < 6) ? 10 : (gd < 9) ? 3 : 2;
         w_shk = (gd > 5) ? 20 : 10;
         r     = $urandom_range(0, 65 + w_exp + w_shk - 1);
         nld   = ($urandom_range(0, 7) == 0) ? LD_W'($urandom_range(0, 15))
                                             : LD_W'($urandom_range(0, gd));
         if (r < 18)             op = OP_LOOKUP;
         else if (r < 42)        op = OP_SET;
         else if (r < 52)        op = OP_INCR;
         else if (r < 62)        op = OP_DECR;
         else if (r < 65)        op = OP_W'($urandom_range(6, 7));
         else if (r < 65 + w_exp) op = OP_EXPAND;
         else                    op = OP_SHRINK;

         if (op == OP_SHRINK) begin
            // often clear the way first: step every slot at the global depth down, if at most PREP_MAX
            if (gd > 0 && $urandom_range(0, 1) == 0) begin
               prep_q.delete();
               for (int unsigned i = 0; i < size; i++)
                  if (ehd_sb.depth_tab[i] == gd) prep_q.push_back(i);
               if (prep_q.size() <= PREP_MAX)
                  foreach (prep_q[i])
                     send_word(OP_DECR, IDX_W'(prep_q[i]), pick_page(), nld);
            end
            send_word(OP_SHRINK, pick_index(gd > 0 ? size / 2 : 1), pick_page(), nld);
         end else begin
            send_word(op, pick_index(size), pick_page(), nld);
         end
      end
      req_valid <= 1'b0;

      // Let the tail drain, then a short quiet spell
      while (ehd_sb.expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request words and %0d checked results;",
               words_sent, ehd_sb.checked);
      $display("  deepest %0d, %0d full, %0d refused shrinks.",
               ehd_sb.max_gdepth, ehd_sb.full_seen, ehd_sb.refused_seen);
      $display("Per operation: lookup %0d set %0d incr %0d decr %0d",
               ehd_sb.op_seen[0], ehd_sb.op_seen[1], ehd_sb.op_seen[2],
               ehd_sb.op_seen[3]);
      $display("  expand %0d shrink %0d spare %0d",
               ehd_sb.op_seen[4], ehd_sb.op_seen[5],
               ehd_sb.op_seen[6] + ehd_sb.op_seen[7]);
      if (ehd_sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ehd_pkg.sv
rtl/core/ehd_ram.sv
rtl/core/ehd_sequencer.sv
rtl/core/ehd_datapath.sv
rtl/core/extendible_hash_directory.sv
tb/testbench.sv
